[design/rei_pkg.sv]
// ----------------------------------------------------------------------------
// rei_pkg
// shared types and constants of the ray / ellipsoid intersection block
// ----------------------------------------------------------------------------
package rei_pkg;

  // coordinate width of origin, direction and centre, signed fixed point
  localparam int unsigned COORD_W = 32;
  // width of distances and radii, unsigned fixed point
  localparam int unsigned T_W     = 31;
  localparam int unsigned RAD_W   = 31;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_T_MIN    = 3'd6;

  // reset values of the registers
  localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;
  localparam logic [T_W-1:0]   T_MIN_RST  = 31'd7;

  // ray request
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic [T_W-1:0]            t_limit;
  } ray_req_t;

  // intersection response
  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] t_out;
  } ray_rsp_t;

endpackage

[design/ray_ellipsoid_intersect.sv]
// ----------------------------------------------------------------------------
// ray_ellipsoid_intersect
// pipelined ray versus axis-aligned ellipsoid test, when not stalled one ray per clock
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  ray       in         in_valid_i / in_ready_o   in_req_i   (ray_req_t)
//  result    out        out_valid_o / out_ready_i out_rsp_o  (ray_rsp_t)
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// a new request enters every clock while the pipe advances; on its way to the
// output register the result passes the 30 step normalising divide, the 64 step
// square root and the 31 step root divide, each one bit per stage
// the whole pipe moves as one: it advances whenever the output register is
// empty or being read, so a stall at the output freezes every stage
// reset clears the stage valid bits and loads the register reset values
//
module ray_ellipsoid_intersect import rei_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // ray requests
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ray_req_t              in_req_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ray_rsp_t              out_rsp_o,
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // widths
  // --------------------------------------------------------------------------
  localparam int unsigned CW        = COORD_W;
  localparam int unsigned NORM_FRAC = 16;              // fraction bits of u, v
  localparam int unsigned NQ_W      = 30;              // magnitude of u, v
  localparam int unsigned NREM_W    = RAD_W + 1;       // normalising remainder
  localparam int unsigned NW        = CW + NORM_FRAC;  // shifted dividend
  localparam int unsigned NCW       = NW + NQ_W + RAD_W;
  localparam int unsigned PR_W      = 2 * NQ_W;        // one product of u, v
  localparam int unsigned A_W       = PR_W + 2;        // sum of three products
  localparam int unsigned HALF_W    = A_W / 2;         // operand half for split
  localparam int unsigned PP_W      = 2 * HALF_W;
  localparam int unsigned PQ_W      = 2 * A_W;
  localparam int unsigned SQI_W     = 128;             // square root operand
  localparam int unsigned SQ_STEPS  = SQI_W / 2;
  localparam int unsigned ROOT_W    = SQ_STEPS;
  localparam int unsigned SQR_W     = ROOT_W + 2;
  localparam int unsigned NUM_W     = ROOT_W + 1;      // root numerator
  localparam int unsigned RQ_W      = T_W;             // root quotient bits
  localparam int unsigned RREM_W    = A_W + 1;
  localparam int unsigned RNW       = NUM_W + FRAC_BITS;
  localparam int unsigned RCW       = RNW + A_W + RQ_W;
  localparam int unsigned DEPTH_W   = $clog2(RQ_W + 1);

  // --------------------------------------------------------------------------
  // stage payloads
  // --------------------------------------------------------------------------
  // lanes 0..2 are the local origin axes, lanes 3..5 the direction axes
  typedef struct packed {
    logic [5:0][CW-1:0] mag;
    logic [5:0]         neg;
    logic [T_W-1:0]     lim;
  } mag_t;

  typedef struct packed {
    logic [5:0][NREM_W-1:0] rem;
    logic [5:0][NQ_W-1:0]   low;
    logic [5:0][NQ_W-1:0]   quo;
    logic [5:0]             sat;
    logic [5:0]             neg;
    logic [T_W-1:0]         lim;
  } ndiv_t;

  typedef struct packed {
    logic [2:0][PR_W-1:0] vv;
    logic [2:0][PR_W-1:0] uu;
    logic [2:0][PR_W-1:0] uv;
    logic [2:0]           uv_neg;
    logic [T_W-1:0]       lim;
  } prod_t;

  typedef struct packed {
    logic [A_W-1:0] a;
    logic [A_W-1:0] sumsq;
    logic [A_W:0]   h;       // two's complement
    logic [T_W-1:0] lim;
  } sum_t;

  typedef struct packed {
    logic [A_W-1:0] a;
    logic [A_W-1:0] hm;
    logic           hneg;
    logic [A_W-1:0] cm;
    logic           cneg;
    logic           anz;
    logic [T_W-1:0] lim;
  } abs_t;

  typedef struct packed {
    logic [PP_W-1:0] h_hh;
    logic [PP_W-1:0] h_hl;
    logic [PP_W-1:0] h_ll;
    logic [PP_W-1:0] q_hh;
    logic [PP_W-1:0] q_hl;
    logic [PP_W-1:0] q_lh;
    logic [PP_W-1:0] q_ll;
    logic [A_W-1:0]  a;
    logic [A_W-1:0]  hm;
    logic            hneg;
    logic            cneg;
    logic            anz;
    logic [T_W-1:0]  lim;
  } pp_t;

  typedef struct packed {
    logic [PQ_W-1:0] p;
    logic [PQ_W-1:0] q;
    logic [A_W-1:0]  a;
    logic [A_W-1:0]  hm;
    logic            hneg;
    logic            cneg;
    logic            anz;
    logic [T_W-1:0]  lim;
  } pq_t;

  typedef struct packed {
    logic [SQI_W-1:0]  x;
    logic [SQR_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [A_W-1:0]    a;
    logic [A_W-1:0]    hm;
    logic              hneg;
    logic              dok;
    logic [T_W-1:0]    lim;
  } sq_t;

  typedef struct packed {
    logic [1:0][NUM_W-1:0] num;   // 0 near root, 1 far root
    logic [1:0]            ok;
    logic [A_W-1:0]        a;
    logic [T_W-1:0]        lim;
  } num_t;

  typedef struct packed {
    logic [1:0][RREM_W-1:0] rem;
    logic [1:0][RQ_W-1:0]   low;
    logic [1:0][RQ_W-1:0]   quo;
    logic [1:0]             sat;
    logic [1:0]             ok;
    logic [A_W-1:0]         a;
    logic [T_W-1:0]         lim;
  } rdiv_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [2:0][CW-1:0]    centre_q;
  logic [2:0][RAD_W-1:0] radius_q;
  logic [T_W-1:0]        t_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0;
      radius_q <= {RADIUS_RST, RADIUS_RST, RADIUS_RST};
      t_min_q  <= T_MIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTRE_X: centre_q[0] <= cfg_data_i[CW-1:0];
        CFG_CENTRE_Y: centre_q[1] <= cfg_data_i[CW-1:0];
        CFG_CENTRE_Z: centre_q[2] <= cfg_data_i[CW-1:0];
        CFG_RADIUS_X: radius_q[0] <= cfg_data_i[RAD_W-1:0];
        CFG_RADIUS_Y: radius_q[1] <= cfg_data_i[RAD_W-1:0];
        CFG_RADIUS_Z: radius_q[2] <= cfg_data_i[RAD_W-1:0];
        CFG_T_MIN:    t_min_q     <= cfg_data_i[T_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero radius acts as one ulp; lane k of the divider uses axis k mod 3
  logic [5:0][RAD_W-1:0] lane_rad;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_rad[i]     = (radius_q[i] == '0) ? RAD_W'(1) : radius_q[i];
      lane_rad[i + 3] = lane_rad[i];
    end
  end

  // --------------------------------------------------------------------------
  // global advance: the pipe moves when the output register can take a value
  // --------------------------------------------------------------------------
  logic adv;
  logic out_vld_q;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  ray_req_t in_q;
  logic     in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  in_vld_q <= 1'b0;
    else if (adv) in_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) in_q <= in_req_i;
  end

  // --------------------------------------------------------------------------
  // local origin and magnitudes with signs
  // --------------------------------------------------------------------------
  mag_t mag_d, mag_q;
  logic mag_vld_q;

  always_comb begin
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dir;
    logic [CW:0]        od;
    org = {in_q.origin_z, in_q.origin_y, in_q.origin_x};
    dir = {in_q.dir_z, in_q.dir_y, in_q.dir_x};
    mag_d.lim = in_q.t_limit;
    for (int i = 0; i < 3; i++) begin
      od = {org[i][CW-1], org[i]} - {centre_q[i][CW-1], centre_q[i]};
      mag_d.neg[i]     = od[CW];
      mag_d.mag[i]     = od[CW] ? CW'(-od) : od[CW-1:0];
      mag_d.neg[i + 3] = dir[i][CW-1];
      mag_d.mag[i + 3] = dir[i][CW-1] ? -dir[i] : dir[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  mag_vld_q <= 1'b0;
    else if (adv) mag_vld_q <= in_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) mag_q <= mag_d;
  end

  // --------------------------------------------------------------------------
  // normalising divide: mag * 2^16 / radius, one quotient bit per stage
  // --------------------------------------------------------------------------
  function automatic ndiv_t ndiv_step(ndiv_t x, logic [5:0][RAD_W-1:0] r);
    ndiv_t             y;
    logic [NREM_W-1:0] tr;
    y = x;
    for (int k = 0; k < 6; k++) begin
      tr       = {x.rem[k][NREM_W-2:0], x.low[k][NQ_W-1]};
      y.low[k] = {x.low[k][NQ_W-2:0], 1'b0};
      if (tr >= {1'b0, r[k]}) begin
        y.rem[k] = tr - {1'b0, r[k]};
        y.quo[k] = {x.quo[k][NQ_W-2:0], 1'b1};
      end else begin
        y.rem[k] = tr;
        y.quo[k] = {x.quo[k][NQ_W-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  ndiv_t            nd_init;
  ndiv_t            nd_q     [NQ_W+1];
  logic [NQ_W:0]    nd_vld_q;

  always_comb begin
    logic [NW-1:0] n;
    nd_init.lim = mag_q.lim;
    nd_init.neg = mag_q.neg;
    nd_init.quo = '0;
    for (int k = 0; k < 6; k++) begin
      n               = {mag_q.mag[k], {NORM_FRAC{1'b0}}};
      nd_init.sat[k]  = NCW'(n) >= (NCW'(lane_rad[k]) << NQ_W);
      nd_init.rem[k]  = NREM_W'(n >> NQ_W);
      nd_init.low[k]  = n[NQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  nd_vld_q <= '0;
    else if (adv) nd_vld_q <= {nd_vld_q[NQ_W-1:0], mag_vld_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv) nd_q[0] <= nd_init;
  end

  for (genvar g = 0; g < NQ_W; g++) begin : g_ndiv
    always_ff @(posedge clk_i) begin
      if (adv) nd_q[g+1] <= ndiv_step(nd_q[g], lane_rad);
    end
  end

  // --------------------------------------------------------------------------
  // products of the normalised values, saturated at 2^30-1
  // --------------------------------------------------------------------------
  prod_t prod_d, prod_q;
  logic  prod_vld_q;

  always_comb begin
    logic [5:0][NQ_W-1:0] nv;
    for (int k = 0; k < 6; k++) begin
      nv[k] = nd_q[NQ_W].sat[k] ? '1 : nd_q[NQ_W].quo[k];
    end
    prod_d.lim = nd_q[NQ_W].lim;
    for (int i = 0; i < 3; i++) begin
      prod_d.vv[i]     = PR_W'(nv[i+3]) * PR_W'(nv[i+3]);
      prod_d.uu[i]     = PR_W'(nv[i]) * PR_W'(nv[i]);
      prod_d.uv[i]     = PR_W'(nv[i]) * PR_W'(nv[i+3]);
      prod_d.uv_neg[i] = nd_q[NQ_W].neg[i] ^ nd_q[NQ_W].neg[i+3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  prod_vld_q <= 1'b0;
    else if (adv) prod_vld_q <= nd_vld_q[NQ_W];
  end

  always_ff @(posedge clk_i) begin
    if (adv) prod_q <= prod_d;
  end

  // --------------------------------------------------------------------------
  // quadratic coefficients a, h and sum u*u
  // --------------------------------------------------------------------------
  sum_t sum_d, sum_q;
  logic sum_vld_q;

  always_comb begin
    logic [A_W:0] term;
    sum_d.lim   = prod_q.lim;
    sum_d.a     = A_W'(prod_q.vv[0]) + A_W'(prod_q.vv[1]) + A_W'(prod_q.vv[2]);
    sum_d.sumsq = A_W'(prod_q.uu[0]) + A_W'(prod_q.uu[1]) + A_W'(prod_q.uu[2]);
    sum_d.h     = '0;
    for (int i = 0; i < 3; i++) begin
      term    = (A_W+1)'(prod_q.uv[i]);
      sum_d.h = prod_q.uv_neg[i] ? sum_d.h - term : sum_d.h + term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  sum_vld_q <= 1'b0;
    else if (adv) sum_vld_q <= prod_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) sum_q <= sum_d;
  end

  // --------------------------------------------------------------------------
  // magnitudes of h and c = sum u*u - 1
  // --------------------------------------------------------------------------
  abs_t abs_d, abs_q;
  logic abs_vld_q;

  always_comb begin
    logic [A_W:0] c;
    c          = {1'b0, sum_q.sumsq} - ((A_W+1)'(1) << (2 * NORM_FRAC));
    abs_d.a    = sum_q.a;
    abs_d.anz  = sum_q.a != '0;
    abs_d.lim  = sum_q.lim;
    abs_d.hneg = sum_q.h[A_W];
    abs_d.hm   = sum_q.h[A_W] ? A_W'(-sum_q.h) : sum_q.h[A_W-1:0];
    abs_d.cneg = c[A_W];
    abs_d.cm   = c[A_W] ? A_W'(-c) : c[A_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  abs_vld_q <= 1'b0;
    else if (adv) abs_vld_q <= sum_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) abs_q <= abs_d;
  end

  // --------------------------------------------------------------------------
  // h*h and a*c from half-width partial products
  // --------------------------------------------------------------------------
  pp_t pp_d, pp_q;
  logic pp_vld_q;

  always_comb begin
    pp_d.h_hh = PP_W'(abs_q.hm[A_W-1:HALF_W]) * PP_W'(abs_q.hm[A_W-1:HALF_W]);
    pp_d.h_hl = PP_W'(abs_q.hm[A_W-1:HALF_W]) * PP_W'(abs_q.hm[HALF_W-1:0]);
    pp_d.h_ll = PP_W'(abs_q.hm[HALF_W-1:0])   * PP_W'(abs_q.hm[HALF_W-1:0]);
    pp_d.q_hh = PP_W'(abs_q.a[A_W-1:HALF_W])  * PP_W'(abs_q.cm[A_W-1:HALF_W]);
    pp_d.q_hl = PP_W'(abs_q.a[A_W-1:HALF_W])  * PP_W'(abs_q.cm[HALF_W-1:0]);
    pp_d.q_lh = PP_W'(abs_q.a[HALF_W-1:0])    * PP_W'(abs_q.cm[A_W-1:HALF_W]);
    pp_d.q_ll = PP_W'(abs_q.a[HALF_W-1:0])    * PP_W'(abs_q.cm[HALF_W-1:0]);
    pp_d.a    = abs_q.a;
    pp_d.hm   = abs_q.hm;
    pp_d.hneg = abs_q.hneg;
    pp_d.cneg = abs_q.cneg;
    pp_d.anz  = abs_q.anz;
    pp_d.lim  = abs_q.lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  pp_vld_q <= 1'b0;
    else if (adv) pp_vld_q <= abs_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) pp_q <= pp_d;
  end

  pq_t pq_d, pq_q;
  logic pq_vld_q;

  always_comb begin
    pq_d.p = (PQ_W'(pp_q.h_hh) << (2 * HALF_W)) + (PQ_W'(pp_q.h_hl) << (HALF_W + 1))
           + PQ_W'(pp_q.h_ll);
    pq_d.q = (PQ_W'(pp_q.q_hh) << (2 * HALF_W))
           + ((PQ_W'(pp_q.q_hl) + PQ_W'(pp_q.q_lh)) << HALF_W) + PQ_W'(pp_q.q_ll);
    pq_d.a    = pp_q.a;
    pq_d.hm   = pp_q.hm;
    pq_d.hneg = pp_q.hneg;
    pq_d.cneg = pp_q.cneg;
    pq_d.anz  = pp_q.anz;
    pq_d.lim  = pp_q.lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  pq_vld_q <= 1'b0;
    else if (adv) pq_vld_q <= pp_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) pq_q <= pq_d;
  end

  // --------------------------------------------------------------------------
  // discriminant h*h - a*c, then bit-serial integer square root
  // --------------------------------------------------------------------------
  function automatic sq_t sq_step(sq_t x);
    sq_t              y;
    logic [SQR_W-1:0] r2;
    logic [SQR_W-1:0] tr;
    y   = x;
    r2  = {x.rem[SQR_W-3:0], x.x[SQI_W-1:SQI_W-2]};
    tr  = {x.root, 2'b01};
    y.x = {x.x[SQI_W-3:0], 2'b00};
    if (r2 >= tr) begin
      y.rem  = r2 - tr;
      y.root = {x.root[ROOT_W-2:0], 1'b1};
    end else begin
      y.rem  = r2;
      y.root = {x.root[ROOT_W-2:0], 1'b0};
    end
    return y;
  endfunction

  sq_t               sq_init;
  sq_t               sq_q     [SQ_STEPS+1];
  logic [SQ_STEPS:0] sq_vld_q;

  always_comb begin
    sq_init.x    = pq_q.cneg ? SQI_W'(pq_q.p) + SQI_W'(pq_q.q)
                             : SQI_W'(pq_q.p) - SQI_W'(pq_q.q);
    sq_init.dok  = pq_q.anz && (pq_q.cneg || (pq_q.q <= pq_q.p));
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.a    = pq_q.a;
    sq_init.hm   = pq_q.hm;
    sq_init.hneg = pq_q.hneg;
    sq_init.lim  = pq_q.lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  sq_vld_q <= '0;
    else if (adv) sq_vld_q <= {sq_vld_q[SQ_STEPS-1:0], pq_vld_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv) sq_q[0] <= sq_init;
  end

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (adv) sq_q[g+1] <= sq_step(sq_q[g]);
    end
  end

  // --------------------------------------------------------------------------
  // root numerators: near -h - s, far -h + s, each must be positive
  // --------------------------------------------------------------------------
  num_t num_d, num_q;
  logic num_vld_q;

  always_comb begin
    logic [NUM_W-1:0] hm;
    logic [NUM_W-1:0] s;
    hm = NUM_W'(sq_q[SQ_STEPS].hm);
    s  = NUM_W'(sq_q[SQ_STEPS].root);
    num_d.a      = sq_q[SQ_STEPS].a;
    num_d.lim    = sq_q[SQ_STEPS].lim;
    num_d.num[0] = hm - s;
    num_d.ok[0]  = sq_q[SQ_STEPS].dok && sq_q[SQ_STEPS].hneg && (hm > s);
    num_d.num[1] = sq_q[SQ_STEPS].hneg ? hm + s : s - hm;
    num_d.ok[1]  = sq_q[SQ_STEPS].dok && (sq_q[SQ_STEPS].hneg || (s > hm));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  num_vld_q <= 1'b0;
    else if (adv) num_vld_q <= sq_vld_q[SQ_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (adv) num_q <= num_d;
  end

  // --------------------------------------------------------------------------
  // root divide: numerator * 2^FRAC_BITS / a, one quotient bit per stage
  // --------------------------------------------------------------------------
  function automatic rdiv_t rdiv_step(rdiv_t x);
    rdiv_t             y;
    logic [RREM_W-1:0] tr;
    y = x;
    for (int j = 0; j < 2; j++) begin
      tr       = {x.rem[j][RREM_W-2:0], x.low[j][RQ_W-1]};
      y.low[j] = {x.low[j][RQ_W-2:0], 1'b0};
      if (tr >= {1'b0, x.a}) begin
        y.rem[j] = tr - {1'b0, x.a};
        y.quo[j] = {x.quo[j][RQ_W-2:0], 1'b1};
      end else begin
        y.rem[j] = tr;
        y.quo[j] = {x.quo[j][RQ_W-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  rdiv_t          rd_init;
  rdiv_t          rd_q     [RQ_W+1];
  logic [RQ_W:0]  rd_vld_q;

  always_comb begin
    logic [RNW-1:0] n;
    rd_init.a   = num_q.a;
    rd_init.lim = num_q.lim;
    rd_init.ok  = num_q.ok;
    rd_init.quo = '0;
    for (int j = 0; j < 2; j++) begin
      n              = {num_q.num[j], {FRAC_BITS{1'b0}}};
      rd_init.sat[j] = RCW'(n) >= (RCW'(num_q.a) << RQ_W);
      rd_init.rem[j] = RREM_W'(n >> RQ_W);
      rd_init.low[j] = n[RQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  rd_vld_q <= '0;
    else if (adv) rd_vld_q <= {rd_vld_q[RQ_W-1:0], num_vld_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv) rd_q[0] <= rd_init;
  end

  for (genvar g = 0; g < RQ_W; g++) begin : g_rdiv
    always_ff @(posedge clk_i) begin
      if (adv) rd_q[g+1] <= rdiv_step(rd_q[g]);
    end
  end

  // --------------------------------------------------------------------------
  // root selection and output register
  // --------------------------------------------------------------------------
  ray_rsp_t out_d, out_q;

  always_comb begin
    logic [1:0][T_W-1:0] tn;
    logic [1:0]          in_range;
    for (int j = 0; j < 2; j++) begin
      tn[j]       = rd_q[RQ_W].sat[j] ? '1 : rd_q[RQ_W].quo[j];
      in_range[j] = rd_q[RQ_W].ok[j] && (tn[j] > t_min_q) && (tn[j] < rd_q[RQ_W].lim);
    end
    out_d.hit   = |in_range;
    out_d.t_out = in_range[0] ? tn[0] : (in_range[1] ? tn[1] : rd_q[RQ_W].lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= rd_vld_q[RQ_W];
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  localparam logic [DEPTH_W-1:0] RD_LAST = DEPTH_W'(RQ_W);

  // a taken request lands in the input stage
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_vld_q)
    else $error("accepted request lost at input stage");

  // the last divide stage drains into the output register whenever the pipe advances
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && rd_vld_q[RD_LAST] |=> out_vld_q)
    else $error("finished result not loaded into output register");

  // a saturated root can never be reported as a hit
  a_no_sat_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.hit |-> out_q.t_out != '1)
    else $error("saturated distance reported as hit");

endmodule
